[rtl/core/afp_pkg.sv]
// Shared types and constants for the attitude frame parser.
package afp_pkg;

    localparam logic [7:0] SYNC_BYTE = 8'd170;
    localparam logic [7:0] FRAME_ID  = 8'd1;
    localparam logic [7:0] FRAME_LEN = 8'd14;

    // Positions within the payload; the last one is the checksum byte.
    localparam logic [3:0] IDX_ROLL_HI   = 4'd0;
    localparam logic [3:0] IDX_ROLL_LO   = 4'd1;
    localparam logic [3:0] IDX_PITCH_HI  = 4'd2;
    localparam logic [3:0] IDX_PITCH_LO  = 4'd3;
    localparam logic [3:0] IDX_YAW_HI    = 4'd4;
    localparam logic [3:0] IDX_YAW_LO    = 4'd5;
    localparam logic [3:0] IDX_STATE     = 4'd9;
    localparam logic [3:0] IDX_MODE      = 4'd10;
    localparam logic [3:0] IDX_LOCK      = 4'd11;
    localparam logic [3:0] IDX_HEIGHT_HI = 4'd12;
    localparam logic [3:0] IDX_HEIGHT_LO = 4'd13;
    localparam logic [3:0] IDX_CSUM      = 4'd14;

    localparam int FRAME_BITS = 88;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_SYNC1 = 3'd1,
        PH_SYNC2 = 3'd2,
        PH_ID    = 3'd3,
        PH_BODY  = 3'd4
    } t_phase;

    typedef struct packed {
        logic signed [15:0] height;
        logic [7:0]         lock_flag;
        logic [7:0]         flight_mode;
        logic [7:0]         flight_state;
        logic signed [15:0] yaw;
        logic signed [15:0] pitch;
        logic signed [15:0] roll;
    } t_frame;

endpackage

[rtl/core/afp_parser.sv]
// Header hunt state machine and payload field assembly.
module afp_parser (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [7:0]      i_byte,
    output logic            o_frame_valid,
    output afp_pkg::t_frame o_frame
);
    import afp_pkg::*;

    t_phase             r_phase, n_phase;
    logic [3:0]         r_idx, n_idx;
    logic [7:0]         r_hold, n_hold;
    logic signed [15:0] r_roll, n_roll;
    logic signed [15:0] r_pitch, n_pitch;
    logic signed [15:0] r_yaw, n_yaw;
    logic signed [15:0] r_height, n_height;
    logic [7:0]         r_state, n_state;
    logic [7:0]         r_mode, n_mode;
    logic [7:0]         r_lock, n_lock;
    logic               w_last;

    // index 15 cannot occur, but would be handled as the checksum too
    assign w_last = (r_idx >= IDX_CSUM);

    always_comb begin
        n_phase = r_phase;
        if (i_valid) begin
            unique case (r_phase)
                PH_SYNC1: n_phase = (i_byte == SYNC_BYTE) ? PH_SYNC2 : PH_IDLE;
                PH_SYNC2: n_phase = (i_byte == FRAME_ID) ? PH_ID : PH_IDLE;
                PH_ID:    n_phase = (i_byte == FRAME_LEN) ? PH_BODY : PH_IDLE;
                PH_BODY:  n_phase = w_last ? PH_IDLE : PH_BODY;
                default:  n_phase = (i_byte == SYNC_BYTE) ? PH_SYNC1 : PH_IDLE;
            endcase
        end
    end

    always_comb begin
        n_idx    = r_idx;
        n_hold   = r_hold;
        n_roll   = r_roll;
        n_pitch  = r_pitch;
        n_yaw    = r_yaw;
        n_height = r_height;
        n_state  = r_state;
        n_mode   = r_mode;
        n_lock   = r_lock;
        if (i_valid && r_phase == PH_ID) begin
            n_idx = '0;
        end else if (i_valid && r_phase == PH_BODY) begin
            n_idx = w_last ? 4'd0 : r_idx + 4'd1;
            case (r_idx) inside
                IDX_ROLL_HI, IDX_PITCH_HI, IDX_YAW_HI, IDX_HEIGHT_HI: n_hold = i_byte;
                IDX_ROLL_LO:   n_roll   = {r_hold, i_byte};
                IDX_PITCH_LO:  n_pitch  = {r_hold, i_byte};
                IDX_YAW_LO:    n_yaw    = {r_hold, i_byte};
                IDX_HEIGHT_LO: n_height = {r_hold, i_byte};
                IDX_STATE:     n_state  = i_byte;
                IDX_MODE:      n_mode   = i_byte;
                IDX_LOCK:      n_lock   = 8'd1 - i_byte;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_idx   <= '0;
        end else begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hold   <= n_hold;
        r_roll   <= n_roll;
        r_pitch  <= n_pitch;
        r_yaw    <= n_yaw;
        r_height <= n_height;
        r_state  <= n_state;
        r_mode   <= n_mode;
        r_lock   <= n_lock;
    end

    // every field was written earlier in the same frame, so registers are final here
    assign o_frame_valid        = i_valid && r_phase == PH_BODY && w_last;
    assign o_frame.roll         = r_roll;
    assign o_frame.pitch        = r_pitch;
    assign o_frame.yaw          = r_yaw;
    assign o_frame.flight_state = r_state;
    assign o_frame.flight_mode  = r_mode;
    assign o_frame.lock_flag    = r_lock;
    assign o_frame.height       = r_height;

`ifndef ASSERT_OFF
    a_emit_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_frame_valid |=> r_phase == PH_IDLE && r_idx == '0)
        else $error("parser did not return to idle after a frame");

    a_body_starts_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_BODY && $past(r_phase) != PH_BODY |-> r_idx == '0)
        else $error("payload collection did not start at index zero");

    a_idx_holds_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_valid |=> $stable(r_idx) && $stable(r_phase))
        else $error("parser state moved without an item");
`endif

endmodule

[rtl/core/attitude_frame_parser.sv]
// Top level: byte stream in, decoded attitude frames out through a result register.
// A frame appears on m_axis in the cycle after its checksum byte is accepted.
// Throughput: one byte per cycle; s_axis_tready drops only while a finished frame
// waits in the result register and m_axis_tready is low.
// Reset (synchronous, i_rst_n low): parser back to hunting the first sync byte,
// result register emptied; partially collected fields are discarded.
module attitude_frame_parser (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,  // rx_byte[7:0]
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // roll[15:0], pitch[31:16], yaw[47:32], flight_state[55:48],
    // flight_mode[63:56], lock_flag[71:64], height[87:72]
    output logic [afp_pkg::FRAME_BITS-1:0]    m_axis_tdata
);
    import afp_pkg::*;

    logic   w_accept;
    logic   w_frame_valid;
    t_frame w_frame;
    logic   r_out_valid;
    t_frame r_out_frame;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    afp_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_accept),
        .i_byte        (s_axis_tdata),
        .o_frame_valid (w_frame_valid),
        .o_frame       (w_frame)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_frame_valid) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_frame_valid) begin
            r_out_frame <= w_frame;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_frame;

`ifndef ASSERT_OFF
    a_frame_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_frame_valid |=> m_axis_tvalid)
        else $error("decoded frame not presented");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready && !w_frame_valid)
        else $error("result register could be overwritten while stalled");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result register not emptied by reset");
`endif

endmodule
